// ===== hw/rtl/zpmc_pkg.sv =====
// ----------------------------------------------------------------------------
// zpmc_pkg
// Shared types and constants of the 3x3 zero-padded mask convolution unit.
// ----------------------------------------------------------------------------
package zpmc_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS     = 8;
    localparam int MASK_SIDE      = 3;
    localparam int COEF_BITS      = 8;
    localparam int PROD_BITS      = PIXEL_BITS + COEF_BITS;
    localparam int SUM_BITS       = 20;
    localparam int SIZE_BITS      = 11;
    localparam int HEIGHT_LIMIT   = 1024;
    localparam int MASK_ROW_BITS  = MASK_SIDE * COEF_BITS;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;
    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TDATA_BITS = 24;

    localparam logic [SIZE_BITS-1:0]     WIDTH_RESET       = 11'd1024;
    localparam logic [SIZE_BITS-1:0]     HEIGHT_RESET      = 11'd1024;
    localparam logic [MASK_ROW_BITS-1:0] MASK_TOP_RESET    = 24'h000000;
    localparam logic [MASK_ROW_BITS-1:0] MASK_MIDDLE_RESET = 24'h010000;
    localparam logic [MASK_ROW_BITS-1:0] MASK_BOTTOM_RESET = 24'h000000;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_MASK_TOP     = 3'd2,
        CFG_MASK_MIDDLE  = 3'd3,
        CFG_MASK_BOTTOM  = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_FLUSH = 1'b1
    } action_t;

    typedef logic [PIXEL_BITS-1:0]    pixel_t;
    typedef logic [MASK_ROW_BITS-1:0] mask_row_t;
    typedef logic [PROD_BITS-1:0]     prod_t;
    typedef logic [SUM_BITS-1:0]      sum_t;
    typedef logic [SIZE_BITS-1:0]     size_t;

    // per-word control that travels with the line buffer read
    typedef struct packed {
        pixel_t value;
        logic   emit;
        logic   top_off;
        logic   bot_off;
        logic   left_off;
        logic   right_off;
        logic   last;
    } s1_info_t;

endpackage

// ===== hw/rtl/zpmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// zpmc_ctrl
// Input/output position counters, border flags and frame restart; issues the
// line buffer read for each accepted word.
// ----------------------------------------------------------------------------
module zpmc_ctrl #(
    parameter int MAX_WIDTH = zpmc_pkg::MAX_WIDTH_DEF,
    localparam int COL_BITS = $clog2(MAX_WIDTH)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  zpmc_pkg::size_t          width_cfg,
    input  zpmc_pkg::size_t          height_cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     action,
    input  zpmc_pkg::pixel_t         pixel,
    input  logic                     s1_ready,
    output logic                     rd_en,
    output logic [COL_BITS-1:0]      rd_addr,
    output logic                     s1_valid,
    output logic [COL_BITS-1:0]      s1_x,
    output zpmc_pkg::s1_info_t       s1_info
);
    import zpmc_pkg::*;

    localparam int WBITS = $clog2(MAX_WIDTH + 1);

    logic [WBITS-1:0]     w_eff;
    size_t                h_eff;

    logic [COL_BITS-1:0]  in_col_reg, in_col_next;
    size_t                in_row_reg, in_row_next;
    logic [COL_BITS-1:0]  out_col_reg, out_col_next;
    size_t                out_row_reg, out_row_next;
    logic                 frame_done_reg, frame_done_next;
    logic                 s1_valid_reg, s1_valid_next;
    logic [COL_BITS-1:0]  s1_x_reg;
    s1_info_t             s1_info_reg, s1_info_next;

    logic [WBITS:0]       in_col_plus, out_col_plus;
    logic                 in_wrap, out_wrap;
    size_t                row_after;
    logic [SIZE_BITS:0]   out_row_plus;
    logic                 active;

    always_comb
    begin
        if (width_cfg == '0)
            w_eff = WBITS'(1);
        else if (32'(width_cfg) > MAX_WIDTH)
            w_eff = WBITS'(MAX_WIDTH);
        else
            w_eff = WBITS'(width_cfg);

        if (height_cfg == '0)
            h_eff = SIZE_BITS'(1);
        else if (32'(height_cfg) > HEIGHT_LIMIT)
            h_eff = SIZE_BITS'(HEIGHT_LIMIT);
        else
            h_eff = height_cfg;
    end

    assign in_col_plus  = (WBITS+1)'(in_col_reg) + (WBITS+1)'(1);
    assign in_wrap      = in_col_plus >= (WBITS+1)'(w_eff);
    assign row_after    = in_wrap ? in_row_reg + SIZE_BITS'(1) : in_row_reg;
    assign out_col_plus = (WBITS+1)'(out_col_reg) + (WBITS+1)'(1);
    assign out_wrap     = out_col_plus >= (WBITS+1)'(w_eff);
    assign out_row_plus = (SIZE_BITS+1)'(out_row_reg) + (SIZE_BITS+1)'(1);

    // after the last pixel every word is a flush, whatever it says
    assign active   = frame_done_reg || (action_t'(action) == ACT_PIXEL);
    assign in_ready = !s1_valid_reg || s1_ready;
    assign rd_en    = in_valid && in_ready && active;
    assign rd_addr  = in_col_reg;

    always_comb
    begin
        in_col_next     = in_col_reg;
        in_row_next     = in_row_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        frame_done_next = frame_done_reg;

        s1_info_next.value     = frame_done_reg ? '0 : pixel;
        // no output until the window center is one row and one pixel back
        s1_info_next.emit      = !(((in_row_reg == '0)
                                     && ((WBITS+1)'(in_col_reg) <= (WBITS+1)'(w_eff)))
                                   || ((in_row_reg == SIZE_BITS'(1)) && (in_col_reg == '0)));
        s1_info_next.top_off   = out_row_reg == '0;
        s1_info_next.bot_off   = out_row_plus >= (SIZE_BITS+1)'(h_eff);
        s1_info_next.left_off  = out_col_reg == '0;
        s1_info_next.right_off = out_wrap;
        s1_info_next.last      = (out_row_reg >= h_eff)
                                 || ((out_row_plus == (SIZE_BITS+1)'(h_eff)) && out_wrap);

        if (rd_en)
        begin
            in_col_next     = in_wrap ? '0 : COL_BITS'(in_col_plus);
            in_row_next     = row_after;
            frame_done_next = row_after >= h_eff;
            if (s1_info_next.emit)
            begin
                out_col_next = out_wrap ? '0 : COL_BITS'(out_col_plus);
                out_row_next = out_wrap ? out_row_reg + SIZE_BITS'(1) : out_row_reg;
                if (s1_info_next.last)
                begin
                    in_col_next     = '0;
                    in_row_next     = '0;
                    out_col_next    = '0;
                    out_row_next    = '0;
                    frame_done_next = 1'b0;
                end
            end
        end

        if (rd_en)
            s1_valid_next = 1'b1;
        else if (s1_ready)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            frame_done_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            in_col_reg     <= in_col_next;
            in_row_reg     <= in_row_next;
            out_col_reg    <= out_col_next;
            out_row_reg    <= out_row_next;
            frame_done_reg <= frame_done_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_info_reg <= s1_info_next;
            s1_x_reg    <= in_col_reg;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_x     = s1_x_reg;
    assign s1_info  = s1_info_reg;

endmodule

// ===== hw/rtl/zpmc_line_buf.sv =====
// ----------------------------------------------------------------------------
// zpmc_line_buf
// Two line memories holding the two earlier rows; read on accept, written
// back as the word leaves s1, with a bypass if the next word hits the same column.
// ----------------------------------------------------------------------------
module zpmc_line_buf #(
    parameter int MAX_WIDTH = zpmc_pkg::MAX_WIDTH_DEF,
    localparam int COL_BITS = $clog2(MAX_WIDTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [COL_BITS-1:0]  rd_addr,
    input  logic                 s1_valid,
    input  logic                 s1_ready,
    input  logic [COL_BITS-1:0]  s1_x,
    input  zpmc_pkg::pixel_t     s1_value,
    output zpmc_pkg::pixel_t     col_older,
    output zpmc_pkg::pixel_t     col_newer
);
    import zpmc_pkg::*;

    pixel_t older_mem [MAX_WIDTH];
    pixel_t newer_mem [MAX_WIDTH];

    pixel_t older_q_reg;
    pixel_t newer_q_reg;
    logic   fwd_reg;
    pixel_t fwd_old_reg;
    pixel_t fwd_new_reg;
    logic   wr_en;

    assign wr_en     = s1_valid && s1_ready;
    assign col_older = fwd_reg ? fwd_old_reg : older_q_reg;
    assign col_newer = fwd_reg ? fwd_new_reg : newer_q_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            older_q_reg <= older_mem[rd_addr];
            newer_q_reg <= newer_mem[rd_addr];
        end
    end

    // the newer row moves down, the incoming pixel becomes the newer row
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            older_mem[s1_x] <= col_newer;
            newer_mem[s1_x] <= s1_value;
        end
    end

    // a read of the column being written this same edge takes the write data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_reg <= 1'b0;
        else if (rd_en)
            fwd_reg <= s1_valid && (s1_x == rd_addr);
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_old_reg <= col_newer;
            fwd_new_reg <= s1_value;
        end
    end

endmodule

// ===== hw/rtl/zpmc_datapath.sv =====
// ----------------------------------------------------------------------------
// zpmc_datapath
// 3x3 window shift register, border masking, nine coefficient multiplies,
// adder tree and output register.
// ----------------------------------------------------------------------------
module zpmc_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s1_valid,
    output logic                  s1_ready,
    input  zpmc_pkg::s1_info_t    s1_info,
    input  zpmc_pkg::pixel_t      col_older,
    input  zpmc_pkg::pixel_t      col_newer,
    input  zpmc_pkg::mask_row_t   mask_top,
    input  zpmc_pkg::mask_row_t   mask_middle,
    input  zpmc_pkg::mask_row_t   mask_bottom,
    output logic                  out_valid,
    input  logic                  out_ready,
    output zpmc_pkg::sum_t        out_sum,
    output logic                  out_last
);
    import zpmc_pkg::*;

    pixel_t    win_reg   [MASK_SIDE][MASK_SIDE];
    pixel_t    shifted   [MASK_SIDE][MASK_SIDE];
    pixel_t    px_reg    [MASK_SIDE][MASK_SIDE];
    prod_t     prod_reg  [MASK_SIDE][MASK_SIDE];
    mask_row_t mask_rows [MASK_SIDE];
    sum_t      row_sum   [MASK_SIDE];
    sum_t      total;

    logic v2_reg, v3_reg, v4_reg;
    logic last2_reg, last3_reg, last4_reg;
    sum_t sum_reg;
    logic r3, r4, s1_adv;

    assign r4       = !v4_reg || out_ready;
    assign r3       = !v3_reg || r4;
    assign s1_ready = !v2_reg || r3;
    assign s1_adv   = s1_valid && s1_ready;

    assign mask_rows[0] = mask_top;
    assign mask_rows[1] = mask_middle;
    assign mask_rows[2] = mask_bottom;

    always_comb
    begin
        for (int r = 0; r < MASK_SIDE; r++)
            for (int c = 0; c < MASK_SIDE - 1; c++)
                shifted[r][c] = win_reg[r][c+1];
        shifted[0][MASK_SIDE-1] = col_older;
        shifted[1][MASK_SIDE-1] = col_newer;
        shifted[2][MASK_SIDE-1] = s1_info.value;
    end

    // window clears once the last position of the frame has used it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MASK_SIDE; r++)
                for (int c = 0; c < MASK_SIDE; c++)
                    win_reg[r][c] <= '0;
        end
        else if (s1_adv)
        begin
            for (int r = 0; r < MASK_SIDE; r++)
                for (int c = 0; c < MASK_SIDE; c++)
                    win_reg[r][c] <= (s1_info.emit && s1_info.last) ? '0 : shifted[r][c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                v2_reg <= s1_valid && s1_info.emit;
            if (r3)
                v3_reg <= v2_reg;
            if (r4)
                v4_reg <= v3_reg;
        end
    end

    // zero padding: neighbors outside the image are dropped
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_info.emit)
        begin
            last2_reg <= s1_info.last;
            for (int r = 0; r < MASK_SIDE; r++)
                for (int c = 0; c < MASK_SIDE; c++)
                    if ((r == 0 && s1_info.top_off) || (r == MASK_SIDE - 1 && s1_info.bot_off)
                        || (c == 0 && s1_info.left_off)
                        || (c == MASK_SIDE - 1 && s1_info.right_off))
                        px_reg[r][c] <= '0;
                    else
                        px_reg[r][c] <= shifted[r][c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg && r3)
        begin
            last3_reg <= last2_reg;
            for (int r = 0; r < MASK_SIDE; r++)
                for (int c = 0; c < MASK_SIDE; c++)
                    prod_reg[r][c] <= PROD_BITS'(px_reg[r][c])
                                      * PROD_BITS'(mask_rows[r][c*COEF_BITS +: COEF_BITS]);
        end
    end

    always_comb
    begin
        total = '0;
        for (int r = 0; r < MASK_SIDE; r++)
        begin
            row_sum[r] = SUM_BITS'(prod_reg[r][0]) + SUM_BITS'(prod_reg[r][1])
                         + SUM_BITS'(prod_reg[r][2]);
            total = total + row_sum[r];
        end
    end

    always_ff @(posedge clk)
    begin
        if (v3_reg && r4)
        begin
            sum_reg   <= total;
            last4_reg <= last3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_sum   = sum_reg;
    assign out_last  = last4_reg;

endmodule

// ===== hw/rtl/zero_padded_mask_convolution_unit.sv =====
// ----------------------------------------------------------------------------
// zero_padded_mask_convolution_unit
// 3x3 mask convolution over a raster pixel stream with zero padding.
// ----------------------------------------------------------------------------
// Pixels enter on s_axis in raster order, tuser = 0 with the pixel in tdata.
// After the last pixel of the image, send flush words (tuser = 1), one per
// trailing output; width + 1 of them drain the image. A flush before the
// image is complete is taken and dropped. Each m_axis word carries the
// weighted window sum of one position in raster order; tlast marks the last
// position of the image, after which the next pixel starts a new image.
// The output for position k is built from input word k + width + 1 through the
// s1, pixel, product and sum registers. One word is taken per cycle while
// m_axis is not stalled; the two line memories take one read and one write-back
// each per cycle, which sets that figure. A stalled m_axis holds its word while
// input words are still taken until three more output words wait behind it.
// Configuration writes (cfg_*) are taken every cycle and belong between
// images or while the pipeline is empty. Reset clears the counters and the
// window and loads width 1024, height 1024 and a mask that passes the right
// neighbor of the middle row; the line memories need no clearing.
// ----------------------------------------------------------------------------
module zero_padded_mask_convolution_unit #(
    parameter int MAX_WIDTH = zpmc_pkg::MAX_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [zpmc_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,   // [7:0] gray_pixel
    input  logic                                 s_axis_tuser,   // [0] action
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [zpmc_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,   // [19:0] weighted_sum
    output logic                                 m_axis_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [zpmc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [zpmc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import zpmc_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);

    size_t     width_reg;
    size_t     height_reg;
    mask_row_t mask_top_reg;
    mask_row_t mask_middle_reg;
    mask_row_t mask_bottom_reg;

    logic                 rd_en;
    logic [COL_BITS-1:0]  rd_addr;
    logic                 s1_valid;
    logic                 s1_ready;
    logic [COL_BITS-1:0]  s1_x;
    s1_info_t             s1_info;
    pixel_t               col_older;
    pixel_t               col_newer;
    sum_t                 out_sum;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= WIDTH_RESET;
            height_reg      <= HEIGHT_RESET;
            mask_top_reg    <= MASK_TOP_RESET;
            mask_middle_reg <= MASK_MIDDLE_RESET;
            mask_bottom_reg <= MASK_BOTTOM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_IMAGE_WIDTH:  width_reg       <= cfg_data[SIZE_BITS-1:0];
                CFG_IMAGE_HEIGHT: height_reg      <= cfg_data[SIZE_BITS-1:0];
                CFG_MASK_TOP:     mask_top_reg    <= cfg_data[MASK_ROW_BITS-1:0];
                CFG_MASK_MIDDLE:  mask_middle_reg <= cfg_data[MASK_ROW_BITS-1:0];
                CFG_MASK_BOTTOM:  mask_bottom_reg <= cfg_data[MASK_ROW_BITS-1:0];
                default:          ;
            endcase
        end
    end

    zpmc_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .action     (s_axis_tuser),
        .pixel      (s_axis_tdata[PIXEL_BITS-1:0]),
        .s1_ready   (s1_ready),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .s1_valid   (s1_valid),
        .s1_x       (s1_x),
        .s1_info    (s1_info)
    );

    zpmc_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .s1_valid  (s1_valid),
        .s1_ready  (s1_ready),
        .s1_x      (s1_x),
        .s1_value  (s1_info.value),
        .col_older (col_older),
        .col_newer (col_newer)
    );

    zpmc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .s1_valid    (s1_valid),
        .s1_ready    (s1_ready),
        .s1_info     (s1_info),
        .col_older   (col_older),
        .col_newer   (col_newer),
        .mask_top    (mask_top_reg),
        .mask_middle (mask_middle_reg),
        .mask_bottom (mask_bottom_reg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_sum     (out_sum),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_TDATA_BITS'(out_sum);

endmodule

// ===== hw/rtl/zpmc_checker.sv =====
// ----------------------------------------------------------------------------
// zpmc_checker
// Port-level checks of the convolution unit, bound to the top level.
// ----------------------------------------------------------------------------
module zpmc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [zpmc_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
    input logic                                 m_axis_tlast,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready
);
    import zpmc_pkg::*;

    // stalled output word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // an empty pipeline always takes input
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with nothing pending at the output");

    // the pad bits above the sum are always zero
    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_BITS-1:SUM_BITS] == '0)
        else $error("pad bits of output word set");

    a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write not taken");

endmodule

bind zero_padded_mask_convolution_unit zpmc_checker u_zpmc_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x3 zero-padded mask convolution unit.
// Pixel frames and flush words go in on s_axis. A behavioral model of the
// line buffers and the window predicts every output word. Frames come in
// several sizes, masks and idle patterns, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb;

    import zpmc_pkg::*;

    localparam int unsigned LINE_LEN  = MAX_WIDTH_DEF;
    localparam int unsigned SETTLE    = 8;
    localparam int unsigned RAND_WORDS = 950;

    typedef struct packed {
        sum_t sum;
        logic last;
    } window_sum_t;

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata;   // [7:0] gray_pixel
    logic                      s_axis_tuser;   // [0] action
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;   // [19:0] weighted_sum
    logic                      m_axis_tlast;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    // model state
    size_t       width_reg;
    size_t       height_reg;
    mask_row_t   mask_reg [MASK_SIDE];
    pixel_t      older_line [LINE_LEN];
    pixel_t      newer_line [LINE_LEN];
    pixel_t      win [MASK_SIDE][MASK_SIDE];
    int unsigned in_col;
    int unsigned in_row;
    int unsigned out_col;
    int unsigned out_row;
    bit          frame_done;

    window_sum_t pending_sums [$];
    window_sum_t head_sum;
    int unsigned mismatches;
    int unsigned counted_words;
    int unsigned sink_hold;
    bit          idle_on;

    zero_padded_mask_convolution_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned eff_size(input size_t v, input int unsigned top);
        if (v == 0)
            return 1;
        if (v > top)
            return top;
        return 32'(v);
    endfunction

    function automatic void restart_frame();
        in_col     = 0;
        in_row     = 0;
        out_col    = 0;
        out_row    = 0;
        frame_done = 1'b0;
        for (int r = 0; r < MASK_SIDE; r++)
            for (int c = 0; c < MASK_SIDE; c++)
                win[r][c] = '0;
    endfunction

    // one word not dropped: shift the window, update line buffers, maybe emit a sum
    function automatic void predict_window_sum(input action_t act, input pixel_t pix);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned pos;
        int unsigned rr;
        int unsigned cc;
        int unsigned acc;
        pixel_t      v;
        window_sum_t res;
        w   = eff_size(width_reg, LINE_LEN);
        h   = eff_size(height_reg, HEIGHT_LIMIT);
        rr  = out_row;
        cc  = out_col;
        acc = 0;
        if (frame_done)
            v = '0;
        else if (act == ACT_PIXEL)
            v = pix;
        else
            return;
        col = (in_col >= LINE_LEN) ? LINE_LEN - 1 : in_col;
        for (int r = 0; r < MASK_SIDE; r++)
            for (int c = 0; c + 1 < MASK_SIDE; c++)
                win[r][c] = win[r][c + 1];
        win[0][MASK_SIDE - 1] = older_line[col];
        win[1][MASK_SIDE - 1] = newer_line[col];
        win[2][MASK_SIDE - 1] = v;
        older_line[col] = newer_line[col];
        newer_line[col] = v;
        pos = in_row * w + in_col;
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
        frame_done = (in_row >= h);
        if (pos < w + 1)
            return;
        // neighbors outside the image count as zero
        for (int r = 0; r < MASK_SIDE; r++)
        begin
            if ((r == 0 && rr == 0) || (r == 2 && rr + 1 >= h))
                continue;
            for (int c = 0; c < MASK_SIDE; c++)
            begin
                if ((c == 0 && cc == 0) || (c == 2 && cc + 1 >= w))
                    continue;
                acc = acc + 32'(win[r][c]) * 32'(mask_reg[r][c*COEF_BITS +: COEF_BITS]);
            end
        end
        res.sum  = acc[SUM_BITS-1:0];
        res.last = (rr >= h) || (rr + 1 == h && cc + 1 >= w);
        out_col++;
        if (out_col >= w)
        begin
            out_col = 0;
            out_row++;
        end
        if (res.last)
            restart_frame();
        pending_sums.push_back(res);
    endfunction

    task automatic push_word(input action_t act, input pixel_t pix);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_window_sum(act, pix);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:  width_reg   = data[SIZE_BITS-1:0];
            CFG_IMAGE_HEIGHT: height_reg  = data[SIZE_BITS-1:0];
            CFG_MASK_TOP:     mask_reg[0] = data[MASK_ROW_BITS-1:0];
            CFG_MASK_MIDDLE:  mask_reg[1] = data[MASK_ROW_BITS-1:0];
            CFG_MASK_BOTTOM:  mask_reg[2] = data[MASK_ROW_BITS-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // hold the input until every predicted word is back and the pipe is empty
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic drain_frame();
        int unsigned w;
        w = eff_size(width_reg, LINE_LEN);
        for (int unsigned k = 0; k <= w; k++)
        begin
            // a pixel after the image is complete counts as a flush
            if (k == 1 || (k > 1 && $urandom_range(0, 1) == 1))
                push_word(ACT_PIXEL, pixel_t'($urandom));
            else
                push_word(ACT_FLUSH, pixel_t'($urandom));
            counted_words++;
        end
    endtask

    task automatic send_frame(input int pause_at, input bit noisy);
        int unsigned w;
        int unsigned h;
        w = eff_size(width_reg, LINE_LEN);
        h = eff_size(height_reg, HEIGHT_LIMIT);
        for (int k = 0; k < int'(w * h); k++)
        begin
            // flush inside the image is taken and dropped
            if (noisy && $urandom_range(0, 15) == 0)
                push_word(ACT_FLUSH, pixel_t'($urandom));
            push_word(ACT_PIXEL, pixel_t'($urandom));
            counted_words++;
            if (k == pause_at)
                wait_drained();
        end
        drain_frame();
        wait_drained();
    endtask

    task automatic test_identity_mask();
        pixel_t pix [6] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80};
        idle_on = 1'b1;
        write_reg(CFG_IMAGE_WIDTH, 24'd3);
        write_reg(CFG_IMAGE_HEIGHT, 24'd2);
        for (int k = 0; k < 6; k++)
        begin
            push_word(ACT_PIXEL, pix[k]);
            if (k == 1)
                push_word(ACT_FLUSH, 8'hFF);
        end
        drain_frame();
        wait_drained();
    endtask

    task automatic test_full_scale();
        write_reg(CFG_MASK_TOP, 24'hFFFFFF);
        write_reg(CFG_MASK_MIDDLE, 24'hFFFFFF);
        write_reg(CFG_MASK_BOTTOM, 24'hFFFFFF);
        write_reg(CFG_IMAGE_WIDTH, 24'd3);
        write_reg(CFG_IMAGE_HEIGHT, 24'd3);
        for (int k = 0; k < 9; k++)
            push_word(ACT_PIXEL, 8'hFF);
        drain_frame();
        wait_drained();
    endtask

    task automatic test_size_extremes();
        write_reg(CFG_MASK_TOP, 24'h030201);
        write_reg(CFG_MASK_MIDDLE, 24'h0605FF);
        write_reg(CFG_MASK_BOTTOM, 24'h800807);
        // zero size registers clamp to one
        write_reg(CFG_IMAGE_WIDTH, 24'd0);
        write_reg(CFG_IMAGE_HEIGHT, 24'd5);
        send_frame(-1, 1'b0);
        write_reg(CFG_IMAGE_WIDTH, 24'd9);
        write_reg(CFG_IMAGE_HEIGHT, 24'd0);
        send_frame(-1, 1'b1);
    endtask

    task automatic test_random_frames();
        int unsigned stop_at;
        int unsigned w;
        int unsigned h;
        int          pause_at;
        bit          first;
        stop_at = counted_words + RAND_WORDS;
        first   = 1'b1;
        while (counted_words < stop_at)
        begin
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            write_reg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(w));
            write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_BITS'(h));
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_MASK_TOP,
                          ($urandom_range(0, 7) == 0) ? 24'h0 : CFG_DATA_BITS'($urandom));
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_MASK_MIDDLE,
                          ($urandom_range(0, 7) == 0) ? 24'hFFFFFF : CFG_DATA_BITS'($urandom));
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_MASK_BOTTOM,
                          ($urandom_range(0, 7) == 0) ? 24'h0 : CFG_DATA_BITS'($urandom));
            idle_on = ($urandom_range(0, 3) != 0);
            if (first)
                pause_at = int'((w * h) / 2);
            else if ($urandom_range(0, 3) == 0)
                pause_at = int'($urandom_range(0, w * h - 1));
            else
                pause_at = -1;
            first = 1'b0;
            send_frame(pause_at, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        for (int f = 0; f < 6; f++)
        begin
            write_reg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'($urandom_range(1, 12)));
            write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_BITS'($urandom_range(1, 6)));
            write_reg(CFG_MASK_MIDDLE, CFG_DATA_BITS'($urandom));
            send_frame(-1, 1'b1);
        end
    endtask

    // output side: random stall bursts if idle_on, then compare with oldest prediction
    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            sink_hold     <= $urandom_range(1, 18) - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end

        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_sums.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual sum %0d last %b",
                         $time, m_axis_tdata[SUM_BITS-1:0], m_axis_tlast);
                mismatches++;
            end
            else
            begin
                head_sum = pending_sums.pop_front();
                if (m_axis_tdata[SUM_BITS-1:0] !== head_sum.sum)
                begin
                    $display("%0t: weighted sum mismatch, expected %0d, actual %0d",
                             $time, head_sum.sum, m_axis_tdata[SUM_BITS-1:0]);
                    mismatches++;
                end
                if (m_axis_tlast !== head_sum.last)
                begin
                    $display("%0t: frame end mismatch, expected %b, actual %b",
                             $time, head_sum.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #15ms;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        sink_hold     = 0;
        idle_on       = 1'b1;
        mismatches    = 0;
        counted_words = 0;
        width_reg     = WIDTH_RESET;
        height_reg    = HEIGHT_RESET;
        mask_reg[0]   = MASK_TOP_RESET;
        mask_reg[1]   = MASK_MIDDLE_RESET;
        mask_reg[2]   = MASK_BOTTOM_RESET;
        for (int k = 0; k < LINE_LEN; k++)
        begin
            older_line[k] = '0;
            newer_line[k] = '0;
        end
        restart_frame();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_identity_mask();
        test_full_scale();
        test_size_extremes();
        test_random_frames();
        test_steady_stream();

        wait_drained();
        repeat (20) @(posedge clk);
        if (pending_sums.size() != 0)
            $display("%0t: %0d expected sums never arrived", $time, pending_sums.size());
        if (mismatches == 0 && pending_sums.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
